// ===== hdl/wdmt_pkg.sv =====
// Shared types and constants for the wildcard device match table.
package wdmt_pkg;

	localparam int TABLE_DEPTH_DEF = 128;

	localparam logic       OP_REGISTER = 1'b0;
	localparam logic       OP_FIND     = 1'b1;
	localparam logic [1:0] KIND_UNUSED = 2'd0;
	localparam logic [1:0] KIND_PCI    = 2'd1;
	localparam logic [15:0] ANY_ID     = 16'hFFFF;
	localparam logic [7:0]  ANY_CODE   = 8'hFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] vendor_id;
		logic [15:0] device_id;
		logic [7:0]  class_code;
		logic [7:0]  subclass_code;
		logic [7:0]  interface_code;
		logic [7:0]  bus_number;
		logic [4:0]  slot_number;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic clr_wr;
		logic commit;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
		logic clr_last;
	} ctl_sts_t;

endpackage

// ===== hdl/wdmt_datapath.sv =====
// Entry memory, query registers, scan address and match logic.
module wdmt_datapath
	import wdmt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output ctl_sts_t    sts,
	input  logic        operation,
	input  logic [1:0]  device_kind,
	input  logic [15:0] vendor_id,
	input  logic [15:0] device_id,
	input  logic [7:0]  class_code,
	input  logic [7:0]  subclass_code,
	input  logic [7:0]  interface_code,
	input  logic [7:0]  bus_number,
	input  logic [4:0]  slot_number,
	output logic        done,
	output logic        status,
	output logic [7:0]  found_bus,
	output logic [4:0]  found_slot
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	entry_t        mem [TABLE_DEPTH];
	entry_t        query_q;
	logic          op_q;
	entry_t        rdata_s1;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] addr_s1;
	logic          done_q;
	logic          status_q;
	logic [7:0]    bus_q;
	logic [4:0]    slot_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          pci_hit;
	logic          hit;

	// Latch the item and restart the scan on accept.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			query_q <= '{kind: device_kind, vendor_id: vendor_id, device_id: device_id,
				class_code: class_code, subclass_code: subclass_code,
				interface_code: interface_code, bus_number: bus_number,
				slot_number: slot_number};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.load) begin
			addr_q <= '0;
		end else if (cmd.rd || cmd.clr_wr) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	always_comb begin
		wr_en   = cmd.clr_wr || (cmd.commit && op_q == OP_REGISTER);
		wr_addr = cmd.clr_wr ? addr_q : addr_s1;
		wr_data = cmd.clr_wr ? entry_t'('0) : query_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[addr_q];
			addr_s1  <= addr_q;
		end
	end

	always_comb begin
		pci_hit = (rdata_s1.kind == KIND_PCI)
			&& (query_q.vendor_id == ANY_ID || query_q.vendor_id == rdata_s1.vendor_id)
			&& (query_q.device_id == ANY_ID || query_q.device_id == rdata_s1.device_id)
			&& (query_q.class_code == ANY_CODE
				|| query_q.class_code == rdata_s1.class_code)
			&& (query_q.subclass_code == ANY_CODE
				|| query_q.subclass_code == rdata_s1.subclass_code)
			&& (query_q.interface_code == ANY_CODE
				|| query_q.interface_code == rdata_s1.interface_code);
		hit = (op_q == OP_FIND) ? pci_hit : (rdata_s1.kind == KIND_UNUSED);
		sts.hit      = hit;
		sts.last     = (addr_s1 == LAST_ADDR);
		sts.clr_last = (addr_q == LAST_ADDR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// Report location only for a find hit; everything else returns zeros.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= !hit;
			if (hit && op_q == OP_FIND) begin
				bus_q  <= rdata_s1.bus_number;
				slot_q <= rdata_s1.slot_number;
			end else begin
				bus_q  <= '0;
				slot_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign found_bus  = bus_q;
	assign found_slot = slot_q;

endmodule

// ===== hdl/wdmt_ctrl.sv =====
// Controller: clearing pass, accept and the scan sequence.
module wdmt_ctrl
	import wdmt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ctl_sts_t sts,
	output logic     busy,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.hit) begin
					cmd.commit = 1'b1;
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					// advance: fetch the next entry while this one is checked
					cmd.rd = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/wildcard_device_match_table.sv =====
// Top level of the wildcard device match table.
// Usage:
//   Raise start with the item's fields while busy is low; the item is taken at
//   that clock edge. operation 0 registers a device in the lowest unused entry,
//   operation 1 finds the lowest PCI entry matching the query's vendor, device,
//   class, subclass and interface fields, where all ones in a field matches anything.
//   The result is on status, found_bus and found_slot in the cycle that done is
//   high for a single cycle. The receiver cannot stall; it must take the result then.
// Timing:
//   One memory read per cycle, one entry compared per cycle. A scan reads entry 0
//   first and stops at the item's answer or after the last entry. busy is low in
//   the cycle of done, so the next item may be taken at the edge that ends it.
// Reset:
//   After reset a clearing pass writes every entry unused, one entry a cycle,
//   with busy high; then the block is ready.
module wildcard_device_match_table
	import wdmt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [1:0]  device_kind,
	input  logic [15:0] vendor_id,
	input  logic [15:0] device_id,
	input  logic [7:0]  class_code,
	input  logic [7:0]  subclass_code,
	input  logic [7:0]  interface_code,
	input  logic [7:0]  bus_number,
	input  logic [4:0]  slot_number,
	output logic        done,
	output logic        status,
	output logic [7:0]  found_bus,
	output logic [4:0]  found_slot
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	wdmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	wdmt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.device_kind    (device_kind),
		.vendor_id      (vendor_id),
		.device_id      (device_id),
		.class_code     (class_code),
		.subclass_code  (subclass_code),
		.interface_code (interface_code),
		.bus_number     (bus_number),
		.slot_number    (slot_number),
		.done           (done),
		.status         (status),
		.found_bus      (found_bus),
		.found_slot     (found_slot)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result delivered while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (found_bus == 8'd0 && found_slot == 5'd0))
		else $error("failed item returned a nonzero location");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the wildcard device match table.
`timescale 1ns / 100ps

module tb;
	import wdmt_pkg::*;

	localparam int DEPTH       = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1_200_000;
	localparam int PHASE_ITEMS = 650;

	localparam logic [1:0] KIND_OTHER_LO = 2'd2;
	localparam logic [1:0] KIND_OTHER_HI = 2'd3;

	typedef struct packed {
		logic   op;
		entry_t ent;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [7:0] bus;
		logic [4:0] slot;
	} reply_t;

	typedef struct packed {
		cmd_t   cmd;
		logic   fixed;
		reply_t want;
	} dir_row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        start          = 1'b0;
	logic        operation      = 1'b0;
	logic [1:0]  device_kind    = '0;
	logic [15:0] vendor_id      = '0;
	logic [15:0] device_id      = '0;
	logic [7:0]  class_code     = '0;
	logic [7:0]  subclass_code  = '0;
	logic [7:0]  interface_code = '0;
	logic [7:0]  bus_number     = '0;
	logic [4:0]  slot_number    = '0;
	logic        busy;
	logic        done;
	logic        status;
	logic [7:0]  found_bus;
	logic [4:0]  found_slot;

	entry_t   dev_tbl[DEPTH];
	reply_t   pending_replies[$];
	dir_row_t dir_rows[$];
	logic [15:0] id_pool[8];
	logic [7:0]  code_pool[8];

	int sender_idle_pct = 26;
	int err_cnt   = 0;
	int item_cnt  = 0;
	int reg_cnt   = 0;
	int full_cnt  = 0;
	int find_cnt  = 0;
	int hit_cnt   = 0;
	int cycle_cnt = 0;

	wildcard_device_match_table #(.TABLE_DEPTH(DEPTH)) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.device_kind    (device_kind),
		.vendor_id      (vendor_id),
		.device_id      (device_id),
		.class_code     (class_code),
		.subclass_code  (subclass_code),
		.interface_code (interface_code),
		.bus_number     (bus_number),
		.slot_number    (slot_number),
		.done           (done),
		.status         (status),
		.found_bus      (found_bus),
		.found_slot     (found_slot)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("wildcard_device_match_table verification failed");
			$finish;
		end
	end

	function automatic bit field_hit(logic [15:0] query, logic [15:0] stored,
			logic [15:0] wild);
		return query == wild || query == stored;
	endfunction

	// Apply one item to the shadow table and return the reply it must produce.
	function automatic reply_t apply_table_op(cmd_t c);
		reply_t r;
		bit     taken;
		r     = '{status: 1'b1, bus: 8'd0, slot: 5'd0};
		taken = 1'b0;
		if (c.op == OP_REGISTER) begin
			reg_cnt++;
			for (int i = 0; i < DEPTH; i++) begin
				if (!taken && dev_tbl[i].kind == KIND_UNUSED) begin
					dev_tbl[i] = c.ent;
					r.status   = 1'b0;
					taken      = 1'b1;
				end
			end
			if (!taken)
				full_cnt++;
		end else begin
			find_cnt++;
			for (int i = 0; i < DEPTH; i++) begin
				if (!taken && dev_tbl[i].kind == KIND_PCI
						&& field_hit(c.ent.vendor_id, dev_tbl[i].vendor_id, ANY_ID)
						&& field_hit(c.ent.device_id, dev_tbl[i].device_id, ANY_ID)
						&& field_hit({8'h00, c.ent.class_code},
							{8'h00, dev_tbl[i].class_code}, {8'h00, ANY_CODE})
						&& field_hit({8'h00, c.ent.subclass_code},
							{8'h00, dev_tbl[i].subclass_code}, {8'h00, ANY_CODE})
						&& field_hit({8'h00, c.ent.interface_code},
							{8'h00, dev_tbl[i].interface_code}, {8'h00, ANY_CODE})) begin
					r.status = 1'b0;
					r.bus    = dev_tbl[i].bus_number;
					r.slot   = dev_tbl[i].slot_number;
					taken    = 1'b1;
				end
			end
			if (taken)
				hit_cnt++;
		end
		return r;
	endfunction

	function automatic cmd_t mk_cmd(logic op, logic [1:0] kind, logic [15:0] ven,
			logic [15:0] dev, logic [7:0] cls, logic [7:0] sub, logic [7:0] ifc,
			logic [7:0] bus, logic [4:0] slot);
		cmd_t c;
		c.op                 = op;
		c.ent.kind           = kind;
		c.ent.vendor_id      = ven;
		c.ent.device_id      = dev;
		c.ent.class_code     = cls;
		c.ent.subclass_code  = sub;
		c.ent.interface_code = ifc;
		c.ent.bus_number     = bus;
		c.ent.slot_number    = slot;
		return c;
	endfunction

	task automatic add_row(logic op, logic [1:0] kind, logic [15:0] ven, logic [15:0] dev,
			logic [7:0] cls, logic [7:0] sub, logic [7:0] ifc, logic [7:0] bus,
			logic [4:0] slot, logic fixed, logic st, logic [7:0] fb, logic [4:0] fs);
		dir_row_t row;
		row.cmd   = mk_cmd(op, kind, ven, dev, cls, sub, ifc, bus, slot);
		row.fixed = fixed;
		row.want  = '{status: st, bus: fb, slot: fs};
		dir_rows.push_back(row);
	endtask

	// Stored-value pick: mostly repeated pool values so finds see several candidates.
	function automatic logic [15:0] pick_val(bit is_code);
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return is_code ? {8'h00, ANY_CODE} : ANY_ID;
		if (r < 35)
			return is_code ? {8'h00, 8'($urandom)} : 16'($urandom);
		return is_code ? {8'h00, code_pool[$urandom_range(7)]} : id_pool[$urandom_range(7)];
	endfunction

	function automatic logic [15:0] query_val(logic [15:0] stored, bit is_code);
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return is_code ? {8'h00, ANY_CODE} : ANY_ID;
		if (r < 85)
			return stored;
		return pick_val(is_code);
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t   c;
		entry_t tpl;
		bit     have_tpl;
		int     r;
		int     idx;
		c        = mk_cmd(OP_REGISTER, 2'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
		have_tpl = 1'b0;
		tpl      = '0;
		if ($urandom_range(99) < 20) begin
			c.op = OP_REGISTER;
			r    = $urandom_range(99);
			if (r < 50)
				c.ent.kind = KIND_PCI;
			else if (r < 65)
				c.ent.kind = KIND_UNUSED;
			else
				c.ent.kind = 2'($urandom_range(KIND_OTHER_HI, KIND_OTHER_LO));
			c.ent.vendor_id      = pick_val(1'b0);
			c.ent.device_id      = pick_val(1'b0);
			c.ent.class_code     = 8'(pick_val(1'b1));
			c.ent.subclass_code  = 8'(pick_val(1'b1));
			c.ent.interface_code = 8'(pick_val(1'b1));
		end else begin
			c.op = OP_FIND;
			// Aim most queries at a live PCI entry; kind, bus and slot stay random.
			for (int k = 0; k < 8; k++) begin
				idx = $urandom_range(DEPTH - 1);
				if (!have_tpl && dev_tbl[idx].kind == KIND_PCI) begin
					tpl      = dev_tbl[idx];
					have_tpl = 1'b1;
				end
			end
			if (have_tpl && $urandom_range(99) < 85) begin
				c.ent.vendor_id      = query_val(tpl.vendor_id, 1'b0);
				c.ent.device_id      = query_val(tpl.device_id, 1'b0);
				c.ent.class_code     = 8'(query_val({8'h00, tpl.class_code}, 1'b1));
				c.ent.subclass_code  = 8'(query_val({8'h00, tpl.subclass_code}, 1'b1));
				c.ent.interface_code = 8'(query_val({8'h00, tpl.interface_code}, 1'b1));
			end else begin
				c.ent.vendor_id      = pick_val(1'b0);
				c.ent.device_id      = pick_val(1'b0);
				c.ent.class_code     = 8'(pick_val(1'b1));
				c.ent.subclass_code  = 8'(pick_val(1'b1));
				c.ent.interface_code = 8'(pick_val(1'b1));
			end
		end
		return c;
	endfunction

	// Call at a rising edge; returns at the edge that takes the item.
	task automatic issue(cmd_t c, logic fixed, reply_t want);
		reply_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start          <= 1'b1;
		operation      <= c.op;
		device_kind    <= c.ent.kind;
		vendor_id      <= c.ent.vendor_id;
		device_id      <= c.ent.device_id;
		class_code     <= c.ent.class_code;
		subclass_code  <= c.ent.subclass_code;
		interface_code <= c.ent.interface_code;
		bus_number     <= c.ent.bus_number;
		slot_number    <= c.ent.slot_number;
		do
			@(posedge clk);
		while (busy);
		r = apply_table_op(c);
		pending_replies.push_back(fixed ? want : r);
		item_cnt++;
	endtask

	always @(posedge clk) begin : chk_replies
		reply_t want;
		if (done) begin
			if (pending_replies.size() == 0) begin
				$error("result with no item outstanding");
				err_cnt = err_cnt + 1;
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d got %0d", want.status, status);
					err_cnt = err_cnt + 1;
				end
				if (found_bus !== want.bus) begin
					$error("found_bus expected %0d got %0d", want.bus, found_bus);
					err_cnt = err_cnt + 1;
				end
				if (found_slot !== want.slot) begin
					$error("found_slot expected %0d got %0d", want.slot, found_slot);
					err_cnt = err_cnt + 1;
				end
			end
		end
	end

	initial begin
		reply_t no_reply;
		no_reply = '0;
		for (int i = 0; i < DEPTH; i++)
			dev_tbl[i] = '0;
		for (int i = 0; i < 8; i++) begin
			id_pool[i]   = 16'($urandom);
			code_pool[i] = 8'($urandom);
		end

		// empty table, then fills of every kind, then first-hit and wildcard finds
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_PCI, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
			5'h00, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_PCI, 16'hFFFE, 16'hFFFE, 8'hFE, 8'hFE, 8'hFE, 8'hFF,
			5'h1F, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_UNUSED, 16'h5555, 16'hAAAA, 8'h55, 8'hAA, 8'h55, 8'h55,
			5'h0A, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_OTHER_LO, 16'hABCD, 16'h1111, 8'h12, 8'h34, 8'h56, 8'h10,
			5'h01, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_OTHER_HI, 16'hABCD, 16'h2222, 8'h12, 8'h34, 8'h56, 8'h20,
			5'h02, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_PCI, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hC8,
			5'h11, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_UNUSED, 16'h1357, 16'h2468, 8'h01, 8'h02, 8'h03, 8'h01,
			5'h01, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hABCD, 16'h1111, 8'h12, 8'h34, 8'h56, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'h1357, 16'h2468, 8'h01, 8'h02, 8'h03, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_OTHER_HI, 16'hFFFE, 16'hFFFE, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 5'h1F,
			1'b1, 1'b0, 8'hFF, 5'h1F);
		add_row(OP_FIND, KIND_UNUSED, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00,
			1'b0, 1'b0, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_PCI, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 5'h15,
			1'b0, 1'b0, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFF, 16'hFFFE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 5'h00,
			1'b0, 1'b0, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFD, 16'hFFFE, 8'hFE, 8'hFE, 8'hFE, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFE, 16'hFFFD, 8'hFE, 8'hFE, 8'hFE, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFE, 16'hFFFE, 8'hFD, 8'hFE, 8'hFE, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFE, 16'hFFFE, 8'hFE, 8'hFD, 8'hFE, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFE, 16'hFFFE, 8'hFE, 8'hFE, 8'hFD, 8'h00, 5'h00,
			1'b1, 1'b1, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 5'h00,
			1'b0, 1'b0, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFE, 8'hFF, 8'hFF, 8'h00, 5'h00,
			1'b0, 1'b0, 8'h00, 5'h00);
		add_row(OP_REGISTER, KIND_PCI, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h03,
			5'h04, 1'b1, 1'b0, 8'h00, 5'h00);
		add_row(OP_FIND, KIND_UNUSED, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 5'h00,
			1'b0, 1'b0, 8'h00, 5'h00);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].want);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: sender_idle_pct = 26;
				1: sender_idle_pct = 80;
				default: sender_idle_pct = 0;
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue(rand_cmd(), 1'b0, no_reply);
		end
		start <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		// catch any stray result past the last expected one
		repeat (DEPTH + 4) @(posedge clk);

		$display("%0d items: %0d registers (%0d into a full table), %0d finds (%0d hits)",
			item_cnt, reg_cnt, full_cnt, find_cnt, hit_cnt);
		$display("sender gaps at 26, 80 and 0 percent; %0d mismatches", err_cnt);
		if (err_cnt == 0)
			$display("wildcard_device_match_table verification clean");
		else
			$display("wildcard_device_match_table verification failed");
		$finish;
	end

endmodule
